/* rtl/cnd_pkg.sv */
// types, constants and the log fraction table function for the c/n0 estimator
// used by every module of the block; depends on nothing
`default_nettype none

package cnd_pkg;

  localparam int ACC_WIDTH  = 16;
  localparam int NOISE_W    = 32;
  localparam int CFG_W      = 16;
  localparam int SQ_W       = 2 * ACC_WIDTH;
  localparam int PWR_W      = SQ_W + 1;
  localparam int PROD_W     = PWR_W + CFG_W;
  localparam int RECIP_FRAC = 8;
  localparam int C_W        = PROD_W - RECIP_FRAC;
  localparam int FRAC_W     = 16;
  localparam int K_W        = $clog2(C_W);
  localparam int LOG_W      = K_W + FRAC_W;
  localparam int DIFF_W     = LOG_W + 1;
  localparam int DB_K_W     = 18;
  localparam int MAG_W      = LOG_W + DB_K_W;
  localparam int DB_SHIFT   = 24;
  localparam int DB_W       = MAG_W - DB_SHIFT + 1;
  localparam int SUM_W      = DB_W + 2;
  localparam int RES_W      = 16;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  localparam logic [DB_K_W-1:0]      DB_PER_LOG2 = 18'd197283;
  localparam logic signed [RES_W-1:0] RES_MAX    = 16'sh7fff;
  localparam logic signed [RES_W-1:0] RES_MIN    = 16'sh8000;
  localparam logic [CFG_W-1:0]       RECIP_RST   = 16'd256;

  localparam logic [1:0] REG_RECIP     = 2'd0;
  localparam logic [1:0] REG_LOG_BW    = 2'd1;
  localparam logic [1:0] REG_EST_SHIFT = 2'd2;

  typedef struct packed {
    logic signed [ACC_WIDTH-1:0] in_phase;
    logic signed [ACC_WIDTH-1:0] quadrature;
    logic [NOISE_W-1:0]          noise_power;
  } in_t;

  typedef struct packed {
    logic signed [RES_W-1:0] cn0_estimate;
    logic                    estimate_invalid;
  } out_t;

  typedef struct packed {
    logic [CFG_W-1:0]        recip;
    logic signed [CFG_W-1:0] log_bw;
    logic signed [CFG_W-1:0] est_shift;
  } cfg_t;

  typedef struct packed {
    logic lod_en;
    logic norm_en;
  } log_ctl_t;

  typedef struct packed {
    logic inv;
    logic c_zero;
  } flg_t;

  // log2(1 + f / 2^bits) in q.16, truncated, by repeated squaring
  function automatic logic [FRAC_W-1:0] frac_log2(input int unsigned f,
                                                  input int unsigned bits);
    logic [63:0]       m;
    logic [FRAC_W-1:0] r;
    m = (64'd1 << 30) + (64'(f) << (30 - bits));
    r = '0;
    for (int b = FRAC_W - 1; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m    = m >> 1;
        r[b] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/cnd_cfg_regs.sv */
// apb-style configuration registers of the c/n0 estimator
// depends on cnd_pkg
`default_nettype none

module cnd_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [cnd_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [cnd_pkg::PDATA_W-1:0]  pwdata,
  output logic      [cnd_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  output cnd_pkg::cfg_t                     cfg_o
);

  cnd_pkg::cfg_t cfg_q;
  logic [1:0]    idx;
  logic          wr;

  assign idx    = paddr[cnd_pkg::PADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.recip     <= cnd_pkg::RECIP_RST;
      cfg_q.log_bw    <= '0;
      cfg_q.est_shift <= '0;
    end else if (wr) begin
      case (idx)
        cnd_pkg::REG_RECIP:     cfg_q.recip     <= pwdata[cnd_pkg::CFG_W-1:0];
        cnd_pkg::REG_LOG_BW:    cfg_q.log_bw    <= pwdata[cnd_pkg::CFG_W-1:0];
        cnd_pkg::REG_EST_SHIFT: cfg_q.est_shift <= pwdata[cnd_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      cnd_pkg::REG_RECIP:     prdata = cnd_pkg::PDATA_W'(cfg_q.recip);
      cnd_pkg::REG_LOG_BW:    prdata = cnd_pkg::PDATA_W'(cfg_q.log_bw);
      cnd_pkg::REG_EST_SHIFT: prdata = cnd_pkg::PDATA_W'(cfg_q.est_shift);
      default:                prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/cnd_log2.sv */
// two-stage fixed point log2: leading-one search, then normalize and fraction table
// depends on cnd_pkg
`default_nettype none

module cnd_log2 #(
  parameter int WIDTH    = 41,
  parameter int TBL_BITS = 6
) (
  input  wire logic                        clk_i,
  input  wire cnd_pkg::log_ctl_t           ctl_i,
  input  wire logic [WIDTH-1:0]            val_i,
  output logic      [cnd_pkg::LOG_W-1:0]   log_o
);

  localparam int KW      = $clog2(WIDTH);
  localparam int LW      = cnd_pkg::LOG_W;
  localparam int FW      = cnd_pkg::FRAC_W;
  localparam int ENTRIES = 2 ** TBL_BITS;

  logic [FW-1:0]       tbl [ENTRIES];
  logic [KW-1:0]       k_d, k_q, sh;
  logic [WIDTH-1:0]    v_q, vn;
  logic [TBL_BITS-1:0] f;
  logic [LW-1:0]       log_d, log_q;

  for (genvar j = 0; j < ENTRIES; j++) begin : g_tbl
    localparam logic [FW-1:0] ENT = cnd_pkg::frac_log2(j, TBL_BITS);
    assign tbl[j] = ENT;
  end

  always_comb begin
    k_d = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (val_i[i]) k_d = KW'(i);
    end
  end

  assign sh    = KW'(WIDTH - 1) - k_q;
  assign vn    = v_q << sh;
  assign f     = vn[WIDTH-2 -: TBL_BITS];
  assign log_d = (LW'(k_q) << FW) | LW'(tbl[f]);
  assign log_o = log_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.lod_en) begin
      k_q <= k_d;
      v_q <= val_i;
    end
    if (ctl_i.norm_en) begin
      log_q <= log_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/carrier_to_noise_density_estimate.sv */
// top level of the c/n0 estimator: seven-stage pipeline and register port
// depends on cnd_pkg, cnd_cfg_regs and cnd_log2
// throughput: one item per cycle while the output is not stalled; each
// stage holds its item only while the next stage is full and stalled, so
// bubbles close up under backpressure
// reset clears all stage valid bits and loads the registers with their defaults
`default_nettype none

module carrier_to_noise_density_estimate #(
  parameter int LOG_TABLE_BITS = 6
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire cnd_pkg::in_t                 in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output cnd_pkg::out_t                     out_data_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [cnd_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [cnd_pkg::PDATA_W-1:0]  pwdata,
  output logic      [cnd_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready
);

  localparam int NSTG   = 7;
  localparam int AW     = cnd_pkg::ACC_WIDTH;
  localparam int SQ_W   = cnd_pkg::SQ_W;
  localparam int PWR_W  = cnd_pkg::PWR_W;
  localparam int PROD_W = cnd_pkg::PROD_W;
  localparam int C_W    = cnd_pkg::C_W;
  localparam int NW     = cnd_pkg::NOISE_W;
  localparam int LW     = cnd_pkg::LOG_W;
  localparam int DW     = cnd_pkg::DIFF_W;
  localparam int MW     = cnd_pkg::MAG_W;
  localparam int DBW    = cnd_pkg::DB_W;
  localparam int SW     = cnd_pkg::SUM_W;
  localparam int RW     = cnd_pkg::RES_W;

  cnd_pkg::cfg_t     cfg;
  cnd_pkg::log_ctl_t lctl;

  logic [NSTG-1:0] vld_q, vld_d, rdy;

  logic [SQ_W-1:0]   sqi_q, sqq_q;
  logic [NW-1:0]     n0_q, n1_q, n2_q;
  logic [PWR_W-1:0]  pwr;
  logic [PROD_W-1:0] prod_d, prod_q;
  logic [C_W-1:0]    c_raw, c_sub, c2_q;
  cnd_pkg::flg_t     flg2_d, flg2_q, flg3_q, flg4_q, flg5_q;
  logic [LW-1:0]     log_c, log_n;
  logic signed [DW-1:0] diff;
  logic [LW-1:0]     abs_d;
  logic [MW-1:0]     mag_d, mag_q, rnd;
  logic              neg_q;
  logic [DBW-2:0]    db_u;
  logic signed [DBW-1:0] db_s;
  logic signed [SW-1:0]  sum;
  cnd_pkg::out_t     out_d, out_q;

  function automatic logic [AW-1:0] acc_mag(input logic [AW-1:0] v);
    return v[AW-1] ? (~v + AW'(1)) : v;
  endfunction

  cnd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // stage handshake
  always_comb begin
    rdy[NSTG-1] = !vld_q[NSTG-1] || out_ready_i;
    for (int s = NSTG - 2; s >= 0; s--) begin
      rdy[s] = !vld_q[s] || rdy[s+1];
    end
    vld_d[0] = rdy[0] ? in_valid_i : vld_q[0];
    for (int s = 1; s < NSTG; s++) begin
      vld_d[s] = rdy[s] ? vld_q[s-1] : vld_q[s];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NSTG-1];
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // power scaling and noise subtraction
  assign pwr    = PWR_W'(sqi_q) + PWR_W'(sqq_q);
  assign prod_d = PROD_W'(pwr) * PROD_W'(cfg.recip);
  assign c_raw  = prod_q[PROD_W-1:cnd_pkg::RECIP_FRAC];
  assign c_sub  = (c_raw > C_W'(n1_q)) ? (c_raw - C_W'(n1_q)) : c_raw;
  assign flg2_d.c_zero = (c_sub == '0);
  assign flg2_d.inv    = (c_sub == '0) || (n1_q == '0);

  assign lctl.lod_en  = rdy[3];
  assign lctl.norm_en = rdy[4];

  cnd_log2 #(.WIDTH(C_W), .TBL_BITS(LOG_TABLE_BITS)) u_log_c (
    .clk_i (clk_i),
    .ctl_i (lctl),
    .val_i (c2_q),
    .log_o (log_c)
  );

  cnd_log2 #(.WIDTH(NW), .TBL_BITS(LOG_TABLE_BITS)) u_log_n (
    .clk_i (clk_i),
    .ctl_i (lctl),
    .val_i (n2_q),
    .log_o (log_n)
  );

  // db conversion
  assign diff  = $signed({1'b0, log_c}) - $signed({1'b0, log_n});
  assign abs_d = diff[DW-1] ? LW'(-diff) : LW'(diff);
  assign mag_d = MW'(abs_d) * MW'(cnd_pkg::DB_PER_LOG2);

  // rounding, offsets and saturation
  assign rnd  = mag_q + (MW'(1) << (cnd_pkg::DB_SHIFT - 1));
  assign db_u = rnd[MW-1:cnd_pkg::DB_SHIFT];
  assign db_s = neg_q ? -$signed({1'b0, db_u}) : $signed({1'b0, db_u});
  assign sum  = SW'(db_s) + SW'(cfg.log_bw) + SW'(cfg.est_shift);

  always_comb begin
    out_d.estimate_invalid = flg5_q.inv;
    if (flg5_q.inv) begin
      out_d.cn0_estimate = flg5_q.c_zero ? cnd_pkg::RES_MIN : cnd_pkg::RES_MAX;
    end else if (sum > SW'(cnd_pkg::RES_MAX)) begin
      out_d.cn0_estimate = cnd_pkg::RES_MAX;
    end else if (sum < SW'(cnd_pkg::RES_MIN)) begin
      out_d.cn0_estimate = cnd_pkg::RES_MIN;
    end else begin
      out_d.cn0_estimate = sum[RW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      sqi_q <= SQ_W'(acc_mag(in_data_i.in_phase)) * SQ_W'(acc_mag(in_data_i.in_phase));
      sqq_q <= SQ_W'(acc_mag(in_data_i.quadrature))
               * SQ_W'(acc_mag(in_data_i.quadrature));
      n0_q  <= in_data_i.noise_power;
    end
    if (rdy[1]) begin
      prod_q <= prod_d;
      n1_q   <= n0_q;
    end
    if (rdy[2]) begin
      c2_q   <= c_sub;
      n2_q   <= n1_q;
      flg2_q <= flg2_d;
    end
    if (rdy[3]) begin
      flg3_q <= flg2_q;
    end
    if (rdy[4]) begin
      flg4_q <= flg3_q;
    end
    if (rdy[5]) begin
      mag_q  <= mag_d;
      neg_q  <= diff[DW-1];
      flg5_q <= flg4_q;
    end
    if (rdy[6]) begin
      out_q <= out_d;
    end
  end

  a_invalid_saturates : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.estimate_invalid |->
      (out_data_o.cn0_estimate == cnd_pkg::RES_MAX) ||
      (out_data_o.cn0_estimate == cnd_pkg::RES_MIN))
    else $error("invalid estimate not saturated");

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> &vld_q)
    else $error("input stalled while pipeline has a bubble");

  a_out_from_prev_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(vld_q[NSTG-2]))
    else $error("output item appeared without an item in the previous stage");

endmodule

`default_nettype wire

/* verif/cn0_checker.sv */
`timescale 1ns / 1ps
// c/n0 result checker: follows register writes, checks reads, predicts each
// result in order and compares it with the block's output; depends on cnd_pkg
module cn0_checker
  import cnd_pkg::*;
#(
  parameter int TBL_BITS = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  in_t                in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  out_t               out_data_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [PDATA_W-1:0] pwdata_i,
  input  logic [PDATA_W-1:0] prdata_i,
  input  logic               pready_i,
  output int                 err_count_o,
  output int                 pending_o
);

  logic [FRAC_W-1:0]       frac_tbl [2**TBL_BITS];
  logic [CFG_W-1:0]        recip;
  logic signed [CFG_W-1:0] log_bw;
  logic signed [CFG_W-1:0] est_shift;
  out_t                    cn0_q [$];
  int                      errs;

  initial begin
    logic [63:0] m;
    for (int f = 0; f < 2**TBL_BITS; f++) begin
      m = (64'd1 << 30) + (64'(f) << (30 - TBL_BITS));
      frac_tbl[f] = '0;
      for (int b = FRAC_W - 1; b >= 0; b--) begin
        m = (m * m) >> 30;
        if (m >= (64'd1 << 31)) begin
          m = m >> 1;
          frac_tbl[f][b] = 1'b1;
        end
      end
    end
  end

  function automatic longint log2_q16(logic [63:0] v);
    int          k;
    logic [63:0] f;
    k = 63;
    while (k > 0 && !v[k]) k--;
    if (k >= TBL_BITS) f = v >> (k - TBL_BITS);
    else f = v << (TBL_BITS - k);
    f = f & ((64'd1 << TBL_BITS) - 1);
    return (longint'(k) << FRAC_W) + longint'(frac_tbl[f[TBL_BITS-1:0]]);
  endfunction

  function automatic out_t predict_cn0(in_t x);
    logic [63:0] pwr;
    logic [63:0] c;
    logic [63:0] n;
    logic [63:0] mag;
    longint      ii;
    longint      qq;
    longint      d;
    longint      db;
    longint      sum;
    out_t        r;
    ii = x.in_phase;
    qq = x.quadrature;
    if (ii < 0) ii = -ii;
    if (qq < 0) qq = -qq;
    pwr = ii * ii + qq * qq;
    // product stays below 2^49, so no saturation is reachable
    c = (pwr * 64'(recip)) >> RECIP_FRAC;
    n = 64'(x.noise_power);
    if (c > n) c = c - n;
    r.estimate_invalid = 1'b0;
    if (c == 0) begin
      r.estimate_invalid = 1'b1;
      r.cn0_estimate     = RES_MIN;
    end else if (n == 0) begin
      r.estimate_invalid = 1'b1;
      r.cn0_estimate     = RES_MAX;
    end else begin
      d   = log2_q16(c) - log2_q16(n);
      mag = 64'((d < 0) ? -d : d) * 64'(DB_PER_LOG2);
      db  = longint'((mag + (64'd1 << 23)) >> DB_SHIFT);
      if (d < 0) db = -db;
      sum = db + longint'(log_bw) + longint'(est_shift);
      if (sum > 32767) sum = 32767;
      if (sum < -32768) sum = -32768;
      r.cn0_estimate = RES_W'(sum);
    end
    return r;
  endfunction

  function automatic void report_err(string msg);
    errs++;
    if (errs <= 10) $display("ERROR %0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk_i) begin
    out_t             want;
    logic [CFG_W-1:0] reg_val;
    if (!rst_ni) begin
      recip     = RECIP_RST;
      log_bw    = '0;
      est_shift = '0;
      cn0_q.delete();
      errs      = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (cn0_q.size() == 0) begin
          report_err($sformatf("unexpected item est=%0d inv=%0b",
                               out_data_i.cn0_estimate, out_data_i.estimate_invalid));
        end else begin
          want = cn0_q.pop_front();
          if (want.cn0_estimate !== out_data_i.cn0_estimate ||
              want.estimate_invalid !== out_data_i.estimate_invalid)
            report_err($sformatf("expected est=%0d inv=%0b, got est=%0d inv=%0b",
                                 want.cn0_estimate, want.estimate_invalid,
                                 out_data_i.cn0_estimate, out_data_i.estimate_invalid));
        end
      end
      if (in_valid_i && in_ready_i) cn0_q.push_back(predict_cn0(in_data_i));
      if (psel_i && penable_i && pready_i) begin
        case (paddr_i[PADDR_W-1:2])
          REG_RECIP:     reg_val = recip;
          REG_LOG_BW:    reg_val = log_bw;
          REG_EST_SHIFT: reg_val = est_shift;
          default:       reg_val = '0;
        endcase
        if (pwrite_i) begin
          case (paddr_i[PADDR_W-1:2])
            REG_RECIP:     recip     = pwdata_i[CFG_W-1:0];
            REG_LOG_BW:    log_bw    = pwdata_i[CFG_W-1:0];
            REG_EST_SHIFT: est_shift = pwdata_i[CFG_W-1:0];
            default:       ;
          endcase
        end else if (paddr_i[PADDR_W-1:2] <= REG_EST_SHIFT &&
                     prdata_i[CFG_W-1:0] !== reg_val) begin
          report_err($sformatf("register %0d read %h, expected %h",
                               paddr_i[PADDR_W-1:2], prdata_i[CFG_W-1:0], reg_val));
        end
      end
    end
    pending_o   <= cn0_q.size();
    err_count_o <= errs;
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// testbench top for the c/n0 estimator: clock, reset, item, register and output
// ready stimulus and the verdict; depends on cnd_pkg, the block and cn0_checker
module tb;
  import cnd_pkg::*;

  localparam int TBL_BITS      = 6;
  localparam int LATENCY       = 7;
  localparam int IDLE_LIMIT    = 2000;
  localparam int NUM_SETS      = 6;
  localparam int ITEMS_PER_SET = 330;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  in_t                in_data   = '0;
  logic               in_ready;
  logic               out_valid;
  out_t               out_data;
  logic               out_ready = 1'b0;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [PDATA_W-1:0] pwdata    = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               quiet     = 1'b0;
  int                 err_count;
  int                 pending;
  int                 n_sent    = 0;
  int                 n_results = 0;
  int                 idle_cycles = 0;
  int                 ready_hold  = 0;

  carrier_to_noise_density_estimate #(.LOG_TABLE_BITS(TBL_BITS)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  cn0_checker #(.TBL_BITS(TBL_BITS)) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_i    (prdata),
    .pready_i    (pready),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    int r;
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (quiet || r < 60) begin
        out_ready  <= 1'b1;
        ready_hold <= quiet ? 0 : $urandom_range(0, 15);
      end else if (r < 92) begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(0, 2);
      end else begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(7, 39);
      end
    end
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) n_results <= n_results + 1;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic in_t pack_item(logic [15:0] i, logic [15:0] q, logic [31:0] n);
    in_t r;
    r.in_phase    = i;
    r.quadrature  = q;
    r.noise_power = n;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [15:0] corner16();
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      default: return 16'hffff;
    endcase
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v < 0) return '0;
    if (v > longint'(32'hffff_ffff)) return '1;
    return v[31:0];
  endfunction

  task automatic send_item(input in_t x);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx,
                            input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [15:0]        recip_cur;
    logic [15:0]        bw;
    logic [15:0]        sh;
    logic signed [15:0] ii;
    logic signed [15:0] qq;
    logic [31:0]        nn;
    logic [63:0]        c_est;
    int                 sel;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int s = 0; s < NUM_SETS; s++) begin
      wait_drained();
      case (s)
        0: begin recip_cur = RECIP_RST; bw = 16'h0000; sh = 16'h0000; end
        1: begin recip_cur = 16'd1;     bw = 16'h8000; sh = 16'h8000; end
        2: begin recip_cur = 16'hffff;  bw = 16'h7fff; sh = 16'h7fff; end
        3: begin recip_cur = 16'd0;     bw = 16'($urandom);  sh = 16'($urandom);  end
        4: begin
          recip_cur = 16'($urandom);
          bw        = 16'($urandom_range(0, 16384));
          sh        = 16'(int'($urandom_range(0, 2048)) - 1024);
        end
        default: begin
          recip_cur = 16'($urandom_range(128, 4096));
          bw        = 16'($urandom);
          sh        = 16'($urandom);
        end
      endcase
      apb_access(1'b1, REG_RECIP, {16'h0000, recip_cur});
      apb_access(1'b1, REG_LOG_BW, {{16{bw[15]}}, bw});
      apb_access(1'b1, REG_EST_SHIFT, {{16{sh[15]}}, sh});
      apb_access(1'b0, REG_RECIP, '0);
      apb_access(1'b0, REG_LOG_BW, '0);
      apb_access(1'b0, REG_EST_SHIFT, '0);

      if (s == 0) begin
        // zero power, zero noise, equal and adjacent power and noise, extremes
        send_item(pack_item(16'h0000, 16'h0000, 32'd0));
        send_item(pack_item(16'h0000, 16'h0000, 32'd1000));
        send_item(pack_item(16'd100, 16'h0000, 32'd0));
        send_item(pack_item(16'h8000, 16'h8000, 32'd0));
        send_item(pack_item(16'h8000, 16'h8000, 32'hffff_ffff));
        send_item(pack_item(16'h7fff, 16'h7fff, 32'd1));
        send_item(pack_item(16'hffff, 16'h0000, 32'd1));
        send_item(pack_item(16'd1, 16'd1, 32'd1));
        send_item(pack_item(16'd3, 16'd4, 32'd25));
        send_item(pack_item(16'd3, 16'hfffc, 32'd24));
        send_item(pack_item(16'hfffd, 16'd4, 32'd26));
        send_item(pack_item(16'h7fff, 16'h8000, 32'h8000_0000));
        send_item(pack_item(16'h0000, 16'h8000, 32'h4000_0000));
        send_item(pack_item(16'd1, 16'h0000, 32'hffff_ffff));
        send_item(pack_item(16'h8000, 16'h0000, 32'd1));
        send_item(pack_item(16'd12345, 16'ha460, 32'h0012_3456));
        send_item(pack_item(16'h7fff, 16'h7fff, 32'hffff_ffff));
        send_item(pack_item(16'h0001, 16'h0000, 32'd0));
      end

      for (int k = 0; k < ITEMS_PER_SET; k++) begin
        if (k % 100 == 0) quiet <= ($urandom_range(0, 3) == 0);
        if (k == ITEMS_PER_SET / 2) wait_drained();
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
          ii = 16'($urandom);
          qq = 16'($urandom);
        end else if (sel < 8) begin
          ii = 16'($urandom_range(0, 127)) - 16'd64;
          qq = 16'($urandom_range(0, 127)) - 16'd64;
        end else begin
          ii = corner16();
          qq = corner16();
        end
        c_est = (64'(longint'(ii) * longint'(ii) + longint'(qq) * longint'(qq))
                 * 64'(recip_cur)) >> 8;
        sel = $urandom_range(0, 19);
        if (sel < 7) nn = $urandom;
        else if (sel < 13) nn = clamp32(longint'(c_est) + int'($urandom_range(0, 8)) - 4);
        else if (sel < 16) nn = clamp32(longint'(c_est >> $urandom_range(0, 24)));
        else if (sel < 19) nn = $urandom_range(0, 15);
        else nn = '0;
        send_item(pack_item(ii, qq, nn));
      end
    end

    quiet <= 1'b0;
    wait_drained();
    $display("%0d items sent, %0d results checked over %0d register settings",
             n_sent, n_results, NUM_SETS);
    $display("mix: zero power and noise, near-equal power and noise, both saturation ends");
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
